>>> hw/rtl/luenberger_observer_euler_defines.svh
// ----------------------------------------------------------------------------
// Luenberger observer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LUENBERGER_OBSERVER_EULER_DEFINES_SVH
`define LUENBERGER_OBSERVER_EULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LUO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LUO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/luo_pkg.sv
// ----------------------------------------------------------------------------
// Luenberger observer package
// Types, constants and saturation helper shared by the observer modules.
// ----------------------------------------------------------------------------
package luo_pkg;

  localparam int DATA_W  = 32;
  localparam int DT_W    = 20;
  localparam int ACC_W   = 50;
  localparam int PROD_W  = 64;
  localparam int ADDR_W  = 5;
  localparam int STEP_W  = 4;

  // Sequencer schedule: ten products, each consumed in the cycle after it
  // issues; each state is written once its dt product has passed prod_r and scaled_r.
  localparam int NUM_OPS   = 10;
  localparam int UPD_FIRST = 8;
  localparam int LAST_STEP = 11;

  // One microsecond in Q0.32.
  localparam logic [PROD_W-1:0] MICRO_Q032 = 64'd4295;

  localparam logic signed [DATA_W-1:0] RST_GAIN_ZERO     = 32'sd1235354;
  localparam logic signed [DATA_W-1:0] RST_GAIN_ONE      = 32'sd8366470;
  localparam logic signed [DATA_W-1:0] RST_GAIN_TWO      = -32'sd868352;
  localparam logic signed [DATA_W-1:0] RST_GAIN_THREE    = -32'sd655360;
  localparam logic signed [DATA_W-1:0] RST_A_POS         = 32'sd13546;
  localparam logic signed [DATA_W-1:0] RST_A_MID         = -32'sd2205227;
  localparam logic signed [DATA_W-1:0] RST_HEIGHT_OFFSET = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_N_OFFSET      = 32'sd0;

  typedef enum logic [2:0] {
    REG_GAIN_ZERO,
    REG_GAIN_ONE,
    REG_GAIN_TWO,
    REG_GAIN_THREE,
    REG_A_POS,
    REG_A_MID,
    REG_HEIGHT_OFFSET,
    REG_N_OFFSET
  } reg_idx_t;

  typedef enum logic [STEP_W-1:0] {
    OP_G0E,
    OP_APX0,
    OP_AMX2,
    OP_G1E,
    OP_G2E,
    OP_G3E,
    OP_D0T,
    OP_D1T,
    OP_D2T,
    OP_D3T
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_zero;
    logic signed [DATA_W-1:0] gain_one;
    logic signed [DATA_W-1:0] gain_two;
    logic signed [DATA_W-1:0] gain_three;
    logic signed [DATA_W-1:0] a_pos;
    logic signed [DATA_W-1:0] a_mid;
    logic signed [DATA_W-1:0] height_offset;
    logic signed [DATA_W-1:0] n_offset;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       issue_en;
    op_t        issue_op;
    logic       cons_en;
    op_t        cons_op;
    logic       upd_en;
    logic [1:0] upd_idx;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> hw/rtl/luo_if.sv
// ----------------------------------------------------------------------------
// Luenberger observer channels
// Valid/ready channels for measurement items and estimate items.
// ----------------------------------------------------------------------------
interface luo_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       measured_height;
  logic signed [31:0]       drive;
  logic [19:0]              delta_us;

  modport source (output valid, measured_height, drive, delta_us, input ready);
  modport sink (input valid, measured_height, drive, delta_us, output ready);
endinterface

interface luo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height_estimate;
  logic signed [31:0] rate_estimate;
  logic signed [31:0] third_estimate;
  logic signed [31:0] fourth_estimate;

  modport source (output valid, height_estimate, rate_estimate, third_estimate,
                  fourth_estimate, input ready);
  modport sink (input valid, height_estimate, rate_estimate, third_estimate,
                fourth_estimate, output ready);
endinterface

>>> hw/rtl/luenberger_observer_euler.sv
// Result: a result beat is valid in the cycle after its input beat is accepted.
// Sequencing: one input beat at a time; ten products go through the single
// shared 32x32 multiplier, the pipeline drains, and the next beat is accepted
// back in idle once the waiting result beat is no longer stalled.
// Reset: synchronous active-low rst_n clears the estimates to zero, loads the
// register defaults and empties the result register.
// ----------------------------------------------------------------------------
// Luenberger observer with forward Euler integration
// Four-state Q16.16 observer; reports the prior estimate, then advances it.
// ----------------------------------------------------------------------------
module luenberger_observer_euler (
  input  logic                            clk,
  input  logic                            rst_n,
  luo_in_if.sink                          in_ch,
  luo_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [luo_pkg::ADDR_W-1:0]      paddr,
  input  logic [luo_pkg::DATA_W-1:0]      pwdata,
  output logic [luo_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  luo_pkg::cfg_t cfg;
  luo_pkg::cmd_t cmd;
  luo_pkg::sts_t sts;

  luo_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  luo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  luo_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .in_height  (in_ch.measured_height),
    .in_drive   (in_ch.drive),
    .in_dt      (in_ch.delta_us),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_height (out_ch.height_estimate),
    .out_rate   (out_ch.rate_estimate),
    .out_third  (out_ch.third_estimate),
    .out_fourth (out_ch.fourth_estimate)
  );

endmodule

>>> hw/rtl/luo_regs.sv
// ----------------------------------------------------------------------------
// Luenberger observer configuration registers
// APB-style register file holding gains, model coefficients and offsets.
// ----------------------------------------------------------------------------
module luo_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [luo_pkg::ADDR_W-1:0]       paddr,
  input  logic [luo_pkg::DATA_W-1:0]       pwdata,
  output logic [luo_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  output luo_pkg::cfg_t                    cfg
);

  luo_pkg::cfg_t     cfg_r;
  luo_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = luo_pkg::reg_idx_t'(paddr[luo_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_zero     <= luo_pkg::RST_GAIN_ZERO;
      cfg_r.gain_one      <= luo_pkg::RST_GAIN_ONE;
      cfg_r.gain_two      <= luo_pkg::RST_GAIN_TWO;
      cfg_r.gain_three    <= luo_pkg::RST_GAIN_THREE;
      cfg_r.a_pos         <= luo_pkg::RST_A_POS;
      cfg_r.a_mid         <= luo_pkg::RST_A_MID;
      cfg_r.height_offset <= luo_pkg::RST_HEIGHT_OFFSET;
      cfg_r.n_offset      <= luo_pkg::RST_N_OFFSET;
    end else if (wr_en) begin
      case (idx)
        luo_pkg::REG_GAIN_ZERO:     cfg_r.gain_zero     <= pwdata;
        luo_pkg::REG_GAIN_ONE:      cfg_r.gain_one      <= pwdata;
        luo_pkg::REG_GAIN_TWO:      cfg_r.gain_two      <= pwdata;
        luo_pkg::REG_GAIN_THREE:    cfg_r.gain_three    <= pwdata;
        luo_pkg::REG_A_POS:         cfg_r.a_pos         <= pwdata;
        luo_pkg::REG_A_MID:         cfg_r.a_mid         <= pwdata;
        luo_pkg::REG_HEIGHT_OFFSET: cfg_r.height_offset <= pwdata;
        luo_pkg::REG_N_OFFSET:      cfg_r.n_offset      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      luo_pkg::REG_GAIN_ZERO:     prdata = cfg_r.gain_zero;
      luo_pkg::REG_GAIN_ONE:      prdata = cfg_r.gain_one;
      luo_pkg::REG_GAIN_TWO:      prdata = cfg_r.gain_two;
      luo_pkg::REG_GAIN_THREE:    prdata = cfg_r.gain_three;
      luo_pkg::REG_A_POS:         prdata = cfg_r.a_pos;
      luo_pkg::REG_A_MID:         prdata = cfg_r.a_mid;
      luo_pkg::REG_HEIGHT_OFFSET: prdata = cfg_r.height_offset;
      luo_pkg::REG_N_OFFSET:      prdata = cfg_r.n_offset;
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/luo_ctrl.sv
// ----------------------------------------------------------------------------
// Luenberger observer controller
// Sequences the shared multiplier through the ten products of one update.
// ----------------------------------------------------------------------------
`include "luenberger_observer_euler_defines.svh"

module luo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  luo_pkg::sts_t sts,
  output luo_pkg::cmd_t cmd
);

  luo_pkg::state_t             state_r;
  luo_pkg::state_t             state_nxt;
  logic [luo_pkg::STEP_W-1:0]  step_r;
  logic [luo_pkg::STEP_W-1:0]  step_nxt;
  logic [luo_pkg::STEP_W-1:0]  step_prev;
  logic [luo_pkg::STEP_W-1:0]  step_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= luo_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign step_prev = step_r - 4'd1;
  assign step_upd  = step_r - luo_pkg::STEP_W'(luo_pkg::UPD_FIRST);

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.issue_en = 1'b0;
    cmd.issue_op = luo_pkg::op_t'(step_r);
    cmd.cons_en  = 1'b0;
    cmd.cons_op  = luo_pkg::op_t'(step_prev);
    cmd.upd_en   = 1'b0;
    cmd.upd_idx  = step_upd[1:0];
    case (state_r)
      luo_pkg::ST_IDLE: begin
        in_ready = !sts.out_busy;
        if (in_valid && !sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = luo_pkg::ST_RUN;
          step_nxt  = '0;
        end
      end
      luo_pkg::ST_RUN: begin
        cmd.issue_en = step_r < luo_pkg::STEP_W'(luo_pkg::NUM_OPS);
        cmd.cons_en  = (step_r != '0) && (step_r <= luo_pkg::STEP_W'(luo_pkg::NUM_OPS));
        cmd.upd_en   = step_r >= luo_pkg::STEP_W'(luo_pkg::UPD_FIRST);
        step_nxt     = step_r + 4'd1;
        if (step_r == luo_pkg::STEP_W'(luo_pkg::LAST_STEP)) begin
          state_nxt = luo_pkg::ST_IDLE;
          step_nxt  = '0;
        end
      end
      default: begin
        state_nxt = luo_pkg::ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  `LUO_ASSERT_NEXT(a_accept_starts_run, in_valid && in_ready, (state_r == luo_pkg::ST_RUN) && (step_r == '0), "accepted beat did not start the sequence")
  `LUO_ASSERT_NOW(a_idle_quiet, state_r == luo_pkg::ST_IDLE, !cmd.issue_en && !cmd.cons_en && !cmd.upd_en, "datapath command issued while idle")
  `LUO_ASSERT_NEXT(a_step_advances, (state_r == luo_pkg::ST_RUN) && (step_r != luo_pkg::STEP_W'(luo_pkg::LAST_STEP)), (state_r == luo_pkg::ST_RUN) && (step_r == $past(step_r) + 4'd1), "sequence step skipped or stalled")

endmodule

>>> hw/rtl/luo_dp.sv
// ----------------------------------------------------------------------------
// Luenberger observer datapath
// Estimate state, shared 32x32 magnitude multiplier, accumulation and output.
// ----------------------------------------------------------------------------
`include "luenberger_observer_euler_defines.svh"

module luo_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  luo_pkg::cmd_t                       cmd,
  output luo_pkg::sts_t                       sts,
  input  luo_pkg::cfg_t                       cfg,
  input  logic signed [luo_pkg::DATA_W-1:0]   in_height,
  input  logic signed [luo_pkg::DATA_W-1:0]   in_drive,
  input  logic [luo_pkg::DT_W-1:0]            in_dt,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [luo_pkg::DATA_W-1:0]   out_height,
  output logic signed [luo_pkg::DATA_W-1:0]   out_rate,
  output logic signed [luo_pkg::DATA_W-1:0]   out_third,
  output logic signed [luo_pkg::DATA_W-1:0]   out_fourth
);

  logic signed [luo_pkg::DATA_W-1:0] x_r [4];
  logic signed [luo_pkg::DATA_W-1:0] d_r [4];
  logic signed [luo_pkg::DATA_W-1:0] e_r;
  logic signed [luo_pkg::DATA_W-1:0] u_r;
  logic [luo_pkg::DT_W-1:0]          dt_r;
  logic signed [luo_pkg::ACC_W-1:0]  acc_r;
  logic [luo_pkg::PROD_W-1:0]        prod_r;
  logic [luo_pkg::PROD_W-1:0]        prod_nxt;
  logic                              neg_r;
  logic [luo_pkg::PROD_W-1:0]        scaled_r;
  logic                              sneg_r;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic signed [luo_pkg::DATA_W-1:0] oh_r, or_r, ot_r, of_r;

  logic [luo_pkg::DATA_W-1:0]        op_a, op_b;
  logic [luo_pkg::DATA_W-1:0]        mag_a, mag_b;
  logic [luo_pkg::PROD_W-1:0]        rnd16;
  logic [47:0]                       r16;
  logic signed [luo_pkg::ACC_W-1:0]  term;
  logic [luo_pkg::PROD_W-1:0]        rnd32;
  logic [luo_pkg::DATA_W-1:0]        m32;
  logic signed [33:0]                step_s;
  logic signed [luo_pkg::ACC_W-1:0]  upd_sum;

  // Operand selection for the product issued this cycle.
  always_comb begin
    op_a = cfg.gain_zero;
    op_b = e_r;
    case (cmd.issue_op)
      luo_pkg::OP_G0E:  begin op_a = cfg.gain_zero;  op_b = e_r;    end
      luo_pkg::OP_APX0: begin op_a = cfg.a_pos;      op_b = x_r[0]; end
      luo_pkg::OP_AMX2: begin op_a = cfg.a_mid;      op_b = x_r[2]; end
      luo_pkg::OP_G1E:  begin op_a = cfg.gain_one;   op_b = e_r;    end
      luo_pkg::OP_G2E:  begin op_a = cfg.gain_two;   op_b = e_r;    end
      luo_pkg::OP_G3E:  begin op_a = cfg.gain_three; op_b = e_r;    end
      luo_pkg::OP_D0T:  begin op_a = d_r[0]; op_b = {12'd0, dt_r}; end
      luo_pkg::OP_D1T:  begin op_a = d_r[1]; op_b = {12'd0, dt_r}; end
      luo_pkg::OP_D2T:  begin op_a = d_r[2]; op_b = {12'd0, dt_r}; end
      luo_pkg::OP_D3T:  begin op_a = d_r[3]; op_b = {12'd0, dt_r}; end
      default: ;
    endcase
  end

  // Sign and magnitude: the most negative value maps to 2^31 unsigned.
  assign mag_a    = op_a[31] ? (~op_a + 32'd1) : op_a;
  assign mag_b    = op_b[31] ? (~op_b + 32'd1) : op_b;
  assign prod_nxt = mag_a * mag_b;

  // Q16.16 product rounded half away from zero, then signed.
  assign rnd16 = prod_r + 64'd32768;
  assign r16   = rnd16[63:16];
  assign term  = neg_r ? -$signed({2'b00, r16}) : $signed({2'b00, r16});

  // Scale by one microsecond in Q0.32, rounded half away from zero.
  assign rnd32   = scaled_r + 64'h0000_0000_8000_0000;
  assign m32     = rnd32[63:32];
  assign step_s  = sneg_r ? -$signed({2'b00, m32}) : $signed({2'b00, m32});
  assign upd_sum = luo_pkg::ACC_W'(x_r[cmd.upd_idx]) + luo_pkg::ACC_W'(step_s);

  assign out_valid_nxt = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        x_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.upd_en) begin
        x_r[cmd.upd_idx] <= luo_pkg::sat32(upd_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r  <= luo_pkg::sat32(luo_pkg::ACC_W'(in_height)
                             - luo_pkg::ACC_W'(cfg.height_offset)
                             - luo_pkg::ACC_W'(x_r[0]));
      u_r  <= in_drive;
      dt_r <= in_dt;
      oh_r <= luo_pkg::sat32(luo_pkg::ACC_W'(x_r[0]) + luo_pkg::ACC_W'(cfg.height_offset));
      or_r <= x_r[1];
      ot_r <= luo_pkg::sat32(luo_pkg::ACC_W'(x_r[2]) + luo_pkg::ACC_W'(cfg.n_offset));
      of_r <= x_r[3];
    end
    if (cmd.issue_en) begin
      prod_r <= prod_nxt;
      neg_r  <= op_a[31] ^ op_b[31];
    end
    if (cmd.cons_en) begin
      case (cmd.cons_op)
        luo_pkg::OP_G0E:  d_r[0] <= luo_pkg::sat32(luo_pkg::ACC_W'(x_r[1]) + term);
        luo_pkg::OP_APX0: acc_r  <= term;
        luo_pkg::OP_AMX2: acc_r  <= acc_r + term;
        luo_pkg::OP_G1E:  d_r[1] <= luo_pkg::sat32(acc_r + term);
        luo_pkg::OP_G2E:  d_r[2] <= luo_pkg::sat32(luo_pkg::ACC_W'(x_r[3])
                                                   + luo_pkg::ACC_W'(u_r) + term);
        luo_pkg::OP_G3E:  d_r[3] <= luo_pkg::sat32(term);
        luo_pkg::OP_D0T, luo_pkg::OP_D1T, luo_pkg::OP_D2T, luo_pkg::OP_D3T: begin
          scaled_r <= prod_r * luo_pkg::MICRO_Q032;
          sneg_r   <= neg_r;
        end
        default: ;
      endcase
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_height   = oh_r;
  assign out_rate     = or_r;
  assign out_third    = ot_r;
  assign out_fourth   = of_r;

  `LUO_ASSERT_NEXT(a_load_shows_result, cmd.load, out_valid_r, "loaded beat not presented")
  `LUO_ASSERT_NEXT(a_state_holds, !cmd.upd_en, $stable(x_r[0]) && $stable(x_r[1]) && $stable(x_r[2]) && $stable(x_r[3]), "estimate changed outside an update")
  `LUO_ASSERT_NEXT(a_out_held, out_valid_r && !out_ready, out_valid_r && $stable(oh_r) && $stable(or_r) && $stable(ot_r) && $stable(of_r), "waiting estimate beat changed")

endmodule
